/* src/fcs_pkg.sv */
// fcs_pkg: request and response types, command and status codes, register indexes
// for the flow session table. No dependencies.
package fcs_pkg;

  // command codes
  localparam logic [2:0] CMD_LOOKUP    = 3'd0;
  localparam logic [2:0] CMD_CREATE    = 3'd1;
  localparam logic [2:0] CMD_BY_ID     = 3'd2;
  localparam logic [2:0] CMD_REMOVE    = 3'd3;
  localparam logic [2:0] CMD_SWEEP     = 3'd4;
  localparam logic [2:0] CMD_TOUCH     = 3'd5;

  // status codes
  localparam logic [2:0] STAT_HIT      = 3'd0;
  localparam logic [2:0] STAT_CREATED  = 3'd1;
  localparam logic [2:0] STAT_MISS     = 3'd2;
  localparam logic [2:0] STAT_FULL     = 3'd3;
  localparam logic [2:0] STAT_DONE     = 3'd4;

  // state classes
  localparam logic [1:0] CLS_NEW       = 2'd0;
  localparam logic [1:0] CLS_SYN_SENT  = 2'd1;
  localparam logic [1:0] CLS_CLOSE     = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 8;
  localparam logic [CFG_IDX_BITS-1:0] REG_SHARD     = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IDLE_TO   = 8'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_HSHAKE_TO = 8'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLOSE_TO  = 8'd3;

  // session id layout
  localparam int unsigned SHARD_BITS = 16;
  localparam int unsigned SLOT_BITS  = 48;
  localparam int unsigned COUNT_BITS = 11;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] pkt_key;
    logic [63:0] session_id;
    logic [63:0] now_time;
    logic [1:0]  state_class;
  } req_t;

  typedef struct packed {
    logic [2:0]            status;
    logic                  is_new;
    logic [63:0]           result_id;
    logic [63:0]           result_key;
    logic [COUNT_BITS-1:0] expired_count;
  } rsp_t;

endpackage

/* src/fcs_cell.sv */
// fcs_cell: one cell of the slot ring, holding one slot record and passing it on
// to the next cell every cycle. Depends on nothing but its parameters.
module fcs_cell #(
  parameter int unsigned KEY_BITS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [KEY_BITS-1:0] key_i,
  input  logic [1:0]          cls_i,
  input  logic [63:0]         time_i,
  output logic                valid_o,
  output logic [KEY_BITS-1:0] key_o,
  output logic [1:0]          cls_o,
  output logic [63:0]         time_o
);

  logic                valid_q;
  logic [KEY_BITS-1:0] key_q;
  logic [1:0]          cls_q;
  logic [63:0]         time_q;

  // occupancy flag, cleared on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // record payload moves along with the flag
  always_ff @(posedge clk_i) begin
    key_q  <= key_i;
    cls_q  <= cls_i;
    time_q <= time_i;
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign cls_o   = cls_q;
  assign time_o  = time_q;

endmodule

/* src/fcs_free_stack.sv */
// fcs_slot_pool: stack of free slot indexes in a memory, slot 0 on top after reset.
// Never-popped positions read their reset value through a low-water mark.
module fcs_slot_pool #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  logic [$clog2(CAPACITY)-1:0]     push_idx_i,
  input  logic                            pop_i,
  output logic [$clog2(CAPACITY+1)-1:0]   count_o,
  output logic [$clog2(CAPACITY)-1:0]     top_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [IW-1:0] mem [CAPACITY];
  logic [CW-1:0] fc_q, fc_d;
  logic [CW-1:0] lw_q, lw_d;
  logic [CW-1:0] fc_dec;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] rd_q;
  logic [IW-1:0] init_q;
  logic          from_mem_q;

  assign fc_dec  = fc_q - 1'b1;
  assign rd_addr = (fc_q == '0) ? '0 : fc_dec[IW-1:0];

  // count and low-water mark
  always_comb begin
    fc_d = fc_q;
    lw_d = lw_q;
    if (pop_i) begin
      fc_d = fc_dec;
      if (fc_dec < lw_q) begin
        lw_d = fc_dec;
      end
    end else if (push_i) begin
      fc_d = fc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q <= CW'(CAPACITY);
      lw_q <= CW'(CAPACITY);
    end else begin
      fc_q <= fc_d;
      lw_q <= lw_d;
    end
  end

  // memory write at the count, registered read of the top entry
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[fc_q[IW-1:0]] <= push_idx_i;
    end
    rd_q       <= mem[rd_addr];
    from_mem_q <= (fc_q > lw_q);
    init_q     <= IW'(CW'(CAPACITY) - fc_q);
  end

  assign count_o = fc_q;
  assign top_o   = from_mem_q ? rd_q : init_q;

endmodule

/* src/flow_session_table_core.sv */
// flow_session_table_core: flow session table built as a ring of slot cells that
// rotates one slot per cycle past a single processing point. Uses fcs_pkg,
// fcs_cell and fcs_slot_pool.
//
// The slot records live in a ring of CAPACITY cells; every cycle the ring moves by
// one cell and the record leaving the last cell is examined, updated and fed back
// into the first. Lookup searches one full ring turn; lookup_or_create, when it
// creates, searches a full turn and then waits for the allocated slot to come
// round; lookup by id, remove and touch wait for the addressed slot; sweep waits
// for slot 0 to reach the head so that slots are freed in ascending order.
// Undefined commands and malformed ids skip the ring and go straight to the
// hand-over. A response still held in the output register keeps the finished
// request waiting until it is taken. One request is in work at a time; a finished
// response waits in an output register while the next request is taken. No
// clearing pass is needed after reset.
module flow_session_table_core #(
  parameter int unsigned CAPACITY = 1024,
  parameter int unsigned KEY_BITS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                req_valid_i,
  output logic                                req_ready_o,
  input  fcs_pkg::req_t                       req_i,
  output logic                                rsp_valid_o,
  input  logic                                rsp_ready_i,
  output fcs_pkg::rsp_t                       rsp_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [fcs_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [63:0]                         cfg_data_i
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] LAST = IW'(CAPACITY - 1);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SCAN  = 7'b0000010,
    ST_PLACE = 7'b0000100,
    ST_SEEK  = 7'b0001000,
    ST_SWAIT = 7'b0010000,
    ST_SWEEP = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [fcs_pkg::SHARD_BITS-1:0] shard_q;
  logic [63:0] idle_to_q, hshake_to_q, close_to_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shard_q     <= '0;
      idle_to_q   <= '0;
      hshake_to_q <= '0;
      close_to_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        fcs_pkg::REG_SHARD:     shard_q     <= cfg_data_i[fcs_pkg::SHARD_BITS-1:0];
        fcs_pkg::REG_IDLE_TO:   idle_to_q   <= cfg_data_i;
        fcs_pkg::REG_HSHAKE_TO: hshake_to_q <= cfg_data_i;
        fcs_pkg::REG_CLOSE_TO:  close_to_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // slot ring
  logic                ring_v [CAPACITY];
  logic [KEY_BITS-1:0] ring_k [CAPACITY];
  logic [1:0]          ring_c [CAPACITY];
  logic [63:0]         ring_t [CAPACITY];

  logic                wb_v;
  logic [KEY_BITS-1:0] wb_k;
  logic [1:0]          wb_c;
  logic [63:0]         wb_t;

  logic                head_v;
  logic [KEY_BITS-1:0] head_k;
  logic [1:0]          head_c;
  logic [63:0]         head_t;

  assign head_v = ring_v[CAPACITY-1];
  assign head_k = ring_k[CAPACITY-1];
  assign head_c = ring_c[CAPACITY-1];
  assign head_t = ring_t[CAPACITY-1];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_first
      fcs_cell #(.KEY_BITS(KEY_BITS)) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .valid_i (wb_v),
        .key_i   (wb_k),
        .cls_i   (wb_c),
        .time_i  (wb_t),
        .valid_o (ring_v[g]),
        .key_o   (ring_k[g]),
        .cls_o   (ring_c[g]),
        .time_o  (ring_t[g])
      );
    end else begin : g_rest
      fcs_cell #(.KEY_BITS(KEY_BITS)) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .valid_i (ring_v[g-1]),
        .key_i   (ring_k[g-1]),
        .cls_i   (ring_c[g-1]),
        .time_i  (ring_t[g-1]),
        .valid_o (ring_v[g]),
        .key_o   (ring_k[g]),
        .cls_o   (ring_c[g]),
        .time_o  (ring_t[g])
      );
    end
  end

  // slot index of the record at the head
  logic [IW-1:0] hidx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hidx_q <= '0;
    end else begin
      hidx_q <= (hidx_q == LAST) ? '0 : hidx_q + 1'b1;
    end
  end

  // free slot stack
  logic          push, pop;
  logic [IW-1:0] push_idx;
  logic [CW-1:0] free_cnt;
  logic [IW-1:0] free_top;

  fcs_slot_pool #(.CAPACITY(CAPACITY)) u_free (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_idx_i (push_idx),
    .pop_i      (pop),
    .count_o    (free_cnt),
    .top_o      (free_top)
  );

  // request context
  logic [2:0]          cmd_q, cmd_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [63:0]         now_q, now_d;
  logic [1:0]          cls_q, cls_d;
  logic [IW-1:0]       tgt_q, tgt_d;
  logic [IW-1:0]       cnt_q, cnt_d;
  logic                found_q, found_d;
  logic [IW-1:0]       fidx_q, fidx_d;
  logic [IW-1:0]       aidx_q, aidx_d;
  logic [CW-1:0]       xcnt_q, xcnt_d;
  fcs_pkg::rsp_t       res_q, res_d;
  fcs_pkg::rsp_t       rsp_q, rsp_d;
  logic                rsp_valid_q, rsp_valid_d;

  logic                match;
  logic [63:0]         ttl;
  logic [63:0]         age;
  logic                id_ok;

  function automatic logic [63:0] make_id(input logic [fcs_pkg::SHARD_BITS-1:0] shard,
                                          input logic [IW-1:0] idx);
    make_id = {shard, fcs_pkg::SLOT_BITS'(idx)};
  endfunction

  assign match = head_v && (head_k == key_q);
  assign age   = now_q - head_t;
  assign id_ok = (req_i.session_id[63:fcs_pkg::SLOT_BITS] == shard_q) &&
                 (req_i.session_id[fcs_pkg::SLOT_BITS-1:0] < fcs_pkg::SLOT_BITS'(CAPACITY));

  // class timeout for the head record
  always_comb begin
    case (head_c) inside
      fcs_pkg::CLS_NEW, fcs_pkg::CLS_SYN_SENT: ttl = hshake_to_q;
      fcs_pkg::CLS_CLOSE:                     ttl = close_to_q;
      default:                                ttl = idle_to_q;
    endcase
  end

  assign req_ready_o = (state_q == ST_IDLE);

  // request sequencer
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    now_d       = now_q;
    cls_d       = cls_q;
    tgt_d       = tgt_q;
    cnt_d       = cnt_q;
    found_d     = found_q;
    fidx_d      = fidx_q;
    aidx_d      = aidx_q;
    xcnt_d      = xcnt_q;
    res_d       = res_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q;
    wb_v        = head_v;
    wb_k        = head_k;
    wb_c        = head_c;
    wb_t        = head_t;
    push        = 1'b0;
    pop         = 1'b0;
    push_idx    = hidx_q;

    if (rsp_valid_q && rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          cmd_d        = req_i.cmd;
          key_d        = req_i.pkt_key[KEY_BITS-1:0];
          now_d        = req_i.now_time;
          cls_d        = req_i.state_class;
          tgt_d        = req_i.session_id[IW-1:0];
          cnt_d        = '0;
          found_d      = 1'b0;
          xcnt_d       = '0;
          res_d        = '0;
          res_d.status = fcs_pkg::STAT_DONE;
          unique case (req_i.cmd) inside
            fcs_pkg::CMD_LOOKUP, fcs_pkg::CMD_CREATE: state_d = ST_SCAN;
            fcs_pkg::CMD_BY_ID, fcs_pkg::CMD_REMOVE, fcs_pkg::CMD_TOUCH: begin
              state_d = id_ok ? ST_SEEK : ST_DONE;
            end
            fcs_pkg::CMD_SWEEP: state_d = ST_SWAIT;
            default:            state_d = ST_DONE;
          endcase
        end
      end

      // one full turn looking for the key
      ST_SCAN: begin
        if (match) begin
          found_d = 1'b1;
          fidx_d  = hidx_q;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          if (found_q || match) begin
            res_d.status     = fcs_pkg::STAT_HIT;
            res_d.result_id  = make_id(shard_q, match ? hidx_q : fidx_q);
            res_d.result_key = 64'(key_q);
            state_d          = ST_DONE;
          end else if (cmd_q == fcs_pkg::CMD_LOOKUP) begin
            res_d.status = fcs_pkg::STAT_MISS;
            state_d      = ST_DONE;
          end else if (free_cnt == '0) begin
            res_d.status = fcs_pkg::STAT_FULL;
            state_d      = ST_DONE;
          end else begin
            aidx_d  = free_top;
            state_d = ST_PLACE;
          end
        end
      end

      // wait for the allocated slot and fill it
      ST_PLACE: begin
        if (hidx_q == aidx_q) begin
          wb_v             = 1'b1;
          wb_k             = key_q;
          wb_c             = fcs_pkg::CLS_NEW;
          wb_t             = now_q;
          pop              = 1'b1;
          res_d.status     = fcs_pkg::STAT_CREATED;
          res_d.is_new     = 1'b1;
          res_d.result_id  = make_id(shard_q, aidx_q);
          res_d.result_key = 64'(key_q);
          state_d          = ST_DONE;
        end
      end

      // wait for the addressed slot
      ST_SEEK: begin
        if (hidx_q == tgt_q) begin
          if (head_v) begin
            res_d.status     = fcs_pkg::STAT_HIT;
            res_d.result_id  = make_id(shard_q, tgt_q);
            res_d.result_key = 64'(head_k);
            if (cmd_q == fcs_pkg::CMD_REMOVE) begin
              wb_v = 1'b0;
              push = 1'b1;
            end else if (cmd_q == fcs_pkg::CMD_TOUCH) begin
              wb_c = cls_q;
              wb_t = now_q;
            end
          end
          state_d = ST_DONE;
        end
      end

      // align so slot 0 is the first one swept
      ST_SWAIT: begin
        if (hidx_q == LAST) begin
          cnt_d   = '0;
          state_d = ST_SWEEP;
        end
      end

      ST_SWEEP: begin
        if (head_v && (age > ttl)) begin
          wb_v   = 1'b0;
          push   = 1'b1;
          xcnt_d = xcnt_q + 1'b1;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          res_d.expired_count = fcs_pkg::COUNT_BITS'(xcnt_d);
          state_d             = ST_DONE;
        end
      end

      // hand over to the output register
      ST_DONE: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          rsp_d       = res_q;
          rsp_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rsp_valid_q <= 1'b0;
      found_q     <= 1'b0;
      cnt_q       <= '0;
      xcnt_q      <= '0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      found_q     <= found_d;
      cnt_q       <= cnt_d;
      xcnt_q      <= xcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    key_q  <= key_d;
    now_q  <= now_d;
    cls_q  <= cls_d;
    tgt_q  <= tgt_d;
    fidx_q <= fidx_d;
    aidx_q <= aidx_d;
    res_q  <= res_d;
    rsp_q  <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // a slot is never freed and allocated in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push && pop))
    else $error("free stack push and pop together");

  // allocation only from a non-empty stack
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> (free_cnt != '0))
    else $error("pop from empty free stack");

  // a freed slot is always the one at the head and was occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   push |-> (head_v && (push_idx == hidx_q) && (free_cnt != CW'(CAPACITY))))
    else $error("free of unoccupied slot");

  // the ring position wraps after the last slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (hidx_q == LAST) |=> (hidx_q == '0))
    else $error("ring position did not wrap");

endmodule

/* bench/testbench.sv */
// testbench: self-checking bench for flow_session_table_core, driving requests,
// configuration writes and response stalls and checking each response in order.
// Depends on fcs_pkg and the table core only.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned CAP       = 1024;
  localparam logic [2:0]  CMD_BAD_A = 3'd6;
  localparam logic [2:0]  CMD_BAD_B = 3'd7;
  localparam int unsigned NKEYS     = 40;

  logic clk, rst_ni;
  logic req_valid, req_ready, rsp_valid, rsp_ready, cfg_valid, cfg_ready;
  fcs_pkg::req_t req_d;
  fcs_pkg::rsp_t rsp_q;
  logic [fcs_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [63:0] cfg_data;

  flow_session_table_core #(.CAPACITY(CAP), .KEY_BITS(64)) DUT (
    .clk_i(clk), .rst_ni(rst_ni),
    .req_valid_i(req_valid), .req_ready_o(req_ready), .req_i(req_d),
    .rsp_valid_o(rsp_valid), .rsp_ready_i(rsp_ready), .rsp_o(rsp_q),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // shadow of the session table
  logic [15:0] sh_shard;
  logic [63:0] sh_idle_to, sh_hshake_to, sh_close_to;
  bit          sh_valid [CAP];
  logic [63:0] sh_key   [CAP];
  logic [1:0]  sh_class [CAP];
  logic [63:0] sh_last  [CAP];
  int unsigned sh_free_slots [CAP];
  int unsigned free_cnt;
  int unsigned live_cnt;

  fcs_pkg::req_t pending_reqs[$];
  fcs_pkg::rsp_t expected_rsps[$];
  logic [63:0] key_pool [NKEYS];
  logic [63:0] t_now;

  int unsigned errors, n_checked, n_created, n_full, n_expired;
  bit no_idle, long_stall_req;

  // clock
  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  function automatic logic [63:0] id_of(int unsigned idx);
    return {sh_shard, 48'(idx)};
  endfunction

  function automatic void free_slot(int unsigned idx);
    sh_valid[idx] = 1'b0;
    live_cnt--;
    if (free_cnt < CAP) begin
      sh_free_slots[free_cnt] = idx;
      free_cnt++;
    end
  endfunction

  // expected response of one request, updating the shadow table
  function automatic fcs_pkg::rsp_t table_response(fcs_pkg::req_t r);
    fcs_pkg::rsp_t o;
    int unsigned idx;
    int found;
    logic [63:0] ttl;
    o = '0;
    o.status = fcs_pkg::STAT_DONE;
    case (r.cmd) inside
      fcs_pkg::CMD_LOOKUP, fcs_pkg::CMD_CREATE: begin
        found = -1;
        for (int i = 0; i < CAP; i++)
          if (sh_valid[i] && sh_key[i] == r.pkt_key) found = i;
        if (found >= 0) begin
          o.status = fcs_pkg::STAT_HIT;
          o.result_id = id_of(unsigned'(found));
          o.result_key = r.pkt_key;
        end else if (r.cmd == fcs_pkg::CMD_LOOKUP) begin
          o.status = fcs_pkg::STAT_MISS;
        end else if (free_cnt == 0) begin
          o.status = fcs_pkg::STAT_FULL;
          n_full++;
        end else begin
          free_cnt--;
          idx = sh_free_slots[free_cnt] % CAP;
          sh_valid[idx] = 1'b1;
          sh_key[idx] = r.pkt_key;
          sh_class[idx] = fcs_pkg::CLS_NEW;
          sh_last[idx] = r.now_time;
          live_cnt++;
          n_created++;
          o.status = fcs_pkg::STAT_CREATED;
          o.is_new = 1'b1;
          o.result_id = id_of(idx);
          o.result_key = r.pkt_key;
        end
      end
      fcs_pkg::CMD_BY_ID, fcs_pkg::CMD_REMOVE, fcs_pkg::CMD_TOUCH: begin
        if (r.session_id[63:48] == sh_shard && r.session_id[47:0] < CAP &&
            sh_valid[r.session_id[9:0]]) begin
          idx = 32'(r.session_id[9:0]);
          o.status = fcs_pkg::STAT_HIT;
          o.result_id = id_of(idx);
          o.result_key = sh_key[idx];
          if (r.cmd == fcs_pkg::CMD_REMOVE) begin
            free_slot(idx);
          end else if (r.cmd == fcs_pkg::CMD_TOUCH) begin
            sh_class[idx] = r.state_class;
            sh_last[idx] = r.now_time;
          end
        end
      end
      fcs_pkg::CMD_SWEEP: begin
        for (int i = 0; i < CAP; i++) begin
          if (sh_valid[i]) begin
            if (sh_class[i] == fcs_pkg::CLS_NEW || sh_class[i] == fcs_pkg::CLS_SYN_SENT)
              ttl = sh_hshake_to;
            else if (sh_class[i] == fcs_pkg::CLS_CLOSE) ttl = sh_close_to;
            else ttl = sh_idle_to;
            if (r.now_time - sh_last[i] > ttl) begin
              free_slot(unsigned'(i));
              o.expired_count++;
            end
          end
        end
        n_expired += o.expired_count;
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned p;
    if (no_idle) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  // driver: feeds requests from the pending queue with random gaps
  int unsigned req_gap;
  int unsigned n_accepted;
  always @(posedge clk or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid <= 1'b0;
      req_d <= '0;
      req_gap = 0;
      n_accepted = 0;
    end else begin
      if (req_valid && req_ready) n_accepted++;
      if (!req_valid || req_ready) begin
        if (req_gap > 0) begin
          req_gap--;
          req_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req_d <= pending_reqs.pop_front();
          req_valid <= 1'b1;
          req_gap = pick_gap();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random response stalls, one long hold-off, in-order checking
  int unsigned rsp_hold, long_left;
  bit long_done;
  always @(posedge clk or negedge rst_ni) begin
    fcs_pkg::rsp_t want;
    if (!rst_ni) begin
      rsp_ready <= 1'b0;
      rsp_hold = 0;
      long_left = 0;
      long_done = 1'b0;
      errors = 0;
      n_checked = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        n_checked++;
        if (expected_rsps.size() == 0) begin
          errors++;
          $display("%0t: unexpected response %p", $time, rsp_q);
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_q.status !== want.status || rsp_q.is_new !== want.is_new ||
              rsp_q.result_id !== want.result_id ||
              rsp_q.result_key !== want.result_key ||
              rsp_q.expired_count !== want.expired_count) begin
            errors++;
            $display("%0t: mismatch expected %p actual %p", $time, want, rsp_q);
          end
        end
      end
      if (long_stall_req && !long_done) begin
        long_done = 1'b1;
        long_left = 6000;
      end
      if (long_left > 0) begin
        long_left--;
        rsp_ready <= 1'b0;
      end else if (rsp_hold > 0) begin
        rsp_hold--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
        rsp_hold = pick_gap();
      end
    end
  end

  // stimulus helpers
  function automatic void send(fcs_pkg::req_t r);
    pending_reqs.push_back(r);
    expected_rsps.push_back(table_response(r));
  endfunction

  function automatic fcs_pkg::req_t base_req(logic [2:0] c);
    fcs_pkg::req_t r;
    r = '0;
    r.cmd = c;
    r.pkt_key = {$urandom, $urandom};
    r.session_id = {$urandom, $urandom};
    t_now = t_now + $urandom_range(0, 300);
    r.now_time = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : t_now;
    r.state_class = 2'($urandom_range(0, 3));
    return r;
  endfunction

  function automatic logic [63:0] some_id();
    int unsigned s, p;
    p = $urandom_range(0, 99);
    if (live_cnt > 0 && p < 70) begin
      s = $urandom_range(0, CAP - 1);
      while (!sh_valid[s]) s = (s + 1) % CAP;
      return id_of(s);
    end
    if (p < 78) return {~sh_shard, 48'($urandom_range(0, CAP - 1))};
    if (p < 86) return {sh_shard, {$urandom, 16'($urandom)} | 48'(CAP)};
    if (p < 94) return id_of($urandom_range(0, CAP - 1));
    return {$urandom, $urandom};
  endfunction

  function automatic void send_random();
    fcs_pkg::req_t r;
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 30) r = base_req(fcs_pkg::CMD_CREATE);
    else if (p < 50) r = base_req(fcs_pkg::CMD_LOOKUP);
    else if (p < 65) r = base_req(fcs_pkg::CMD_BY_ID);
    else if (p < 77) r = base_req(fcs_pkg::CMD_REMOVE);
    else if (p < 92) r = base_req(fcs_pkg::CMD_TOUCH);
    else if (p < 97) r = base_req(fcs_pkg::CMD_SWEEP);
    else r = base_req(p[0] ? CMD_BAD_A : CMD_BAD_B);
    if ($urandom_range(0, 9) < 7) r.pkt_key = key_pool[$urandom_range(0, NKEYS - 1)];
    r.session_id = some_id();
    send(r);
  endfunction

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req_valid)
      @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_reg(logic [fcs_pkg::CFG_IDX_BITS-1:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      fcs_pkg::REG_SHARD:     sh_shard = val[15:0];
      fcs_pkg::REG_IDLE_TO:   sh_idle_to = val;
      fcs_pkg::REG_HSHAKE_TO: sh_hshake_to = val;
      fcs_pkg::REG_CLOSE_TO:  sh_close_to = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [15:0] s, logic [63:0] i, logic [63:0] h, logic [63:0] c);
    write_reg(fcs_pkg::REG_SHARD, 64'(s));
    write_reg(fcs_pkg::REG_IDLE_TO, i);
    write_reg(fcs_pkg::REG_HSHAKE_TO, h);
    write_reg(fcs_pkg::REG_CLOSE_TO, c);
  endtask

  // run timeout
  initial begin
    #(64'd400000000);
    $display("FAILURE");
    $finish;
  end

  // main sequence
  initial begin
    fcs_pkg::req_t r;
    logic [63:0] id0;
    rst_ni = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    no_idle = 1'b0;
    long_stall_req = 1'b0;
    n_created = 0; n_full = 0; n_expired = 0;
    sh_shard = '0; sh_idle_to = '0; sh_hshake_to = '0; sh_close_to = '0;
    for (int i = 0; i < CAP; i++) begin
      sh_valid[i] = 1'b0;
      sh_free_slots[i] = CAP - 1 - i;
    end
    free_cnt = CAP;
    live_cnt = 0;
    t_now = 64'd5000;
    for (int i = 0; i < NKEYS; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (4) @(posedge clk);
    rst_ni <= 1'b1;

    set_regs(16'hA5C3, 64'd1000, 64'd500, 64'd200);

    // directed: misses, creates, hits, bad ids, every touch class, removes, undefined codes, sweeps
    r = base_req(fcs_pkg::CMD_LOOKUP); r.pkt_key = '0; send(r);
    r = base_req(fcs_pkg::CMD_CREATE); r.pkt_key = '0; send(r);
    r = base_req(fcs_pkg::CMD_CREATE); r.pkt_key = '1; send(r);
    r = base_req(fcs_pkg::CMD_CREATE); r.pkt_key = '1; send(r);
    r = base_req(fcs_pkg::CMD_LOOKUP); r.pkt_key = '0; send(r);
    id0 = id_of(0);
    r = base_req(fcs_pkg::CMD_BY_ID); r.session_id = id0; send(r);
    r = base_req(fcs_pkg::CMD_BY_ID); r.session_id = {16'h5A3C, 48'd0}; send(r);
    r = base_req(fcs_pkg::CMD_BY_ID); r.session_id = {16'hA5C3, 48'hFFFF_FFFF_FFFF}; send(r);
    r = base_req(fcs_pkg::CMD_BY_ID); r.session_id = id_of(CAP - 1); send(r);
    for (int c = 0; c < 4; c++) begin
      r = base_req(fcs_pkg::CMD_TOUCH); r.session_id = id_of(1); r.state_class = 2'(c);
      send(r);
    end
    r = base_req(fcs_pkg::CMD_TOUCH); r.session_id = id_of(5); send(r);
    r = base_req(fcs_pkg::CMD_REMOVE); r.session_id = id0; send(r);
    r = base_req(fcs_pkg::CMD_REMOVE); r.session_id = id0; send(r);
    r = base_req(fcs_pkg::CMD_CREATE); r.pkt_key = 64'h0123_4567_89AB_CDEF; send(r);
    r = base_req(CMD_BAD_A); send(r);
    r = base_req(CMD_BAD_B); send(r);
    r = base_req(fcs_pkg::CMD_SWEEP); r.now_time = t_now; send(r);
    r = base_req(fcs_pkg::CMD_SWEEP); r.now_time = t_now + 64'd100000; send(r);
    wait_idle();

    // mixed random traffic, with one long response hold-off
    for (int n = 0; n < 350; n++) begin
      send_random();
      if (n == 40) long_stall_req = 1'b1;
    end
    wait_idle();

    // zero timeouts, shard zero, no idling on the request side
    set_regs(16'h0000, 64'd0, 64'd0, 64'd0);
    no_idle = 1'b1;
    for (int n = 0; n < 200; n++) send_random();
    wait_idle();
    no_idle = 1'b0;

    // maximal timeouts: fill the table, overflow it, then sweep nothing
    set_regs(16'hFFFF, '1, '1, '1);
    while (free_cnt > 0) begin
      r = base_req(fcs_pkg::CMD_CREATE);
      send(r);
    end
    for (int n = 0; n < 4; n++) begin
      r = base_req(fcs_pkg::CMD_CREATE); send(r);
    end
    r = base_req(fcs_pkg::CMD_SWEEP); send(r);
    for (int n = 0; n < 20; n++) send_random();
    wait_idle();

    // zero timeouts again: one sweep empties the table
    set_regs(16'h1234, 64'd0, 64'd0, 64'd0);
    r = base_req(fcs_pkg::CMD_SWEEP); r.now_time = t_now + 64'h8000_0000_0000_0000; send(r);
    wait_idle();
    set_regs(16'h1234, 64'd900, 64'd400, 64'd150);
    for (int n = 0; n < 50; n++) send_random();

    // drain
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("run: %0d requests accepted, %0d responses checked, %0d mismatches",
             n_accepted, n_checked, errors);
    $display("run: %0d sessions created, %0d table-full answers, %0d expired by sweeps",
             n_created, n_full, n_expired);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
